// ===== design/rycp_pkg.sv =====
package rycp_pkg;

    // Fixed widths set by the register map and the pixel format
    localparam int CFG_W   = 13;   // widest configuration register
    localparam int IDX_W   = 2;    // register index
    localparam int MODE_W  = 2;
    localparam int PIX_W   = 8;
    localparam int POS_W   = 13;   // column / row as carried through the queue
    localparam int SIZE_W  = 14;   // effective size and stride, up to 8192 + 15
    localparam int ADDR_W  = 24;
    localparam int PROD_W  = 24;   // 8-bit sample times 16-bit coefficient
    localparam int SUM_W   = 27;   // signed accumulator

    // Queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_CHROMA_MODE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Chroma sampling modes; the unused code acts as 4:2:2
    localparam logic [MODE_W-1:0] CM_420 = 2'd0;
    localparam logic [MODE_W-1:0] CM_422 = 2'd1;
    localparam logic [MODE_W-1:0] CM_444 = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // Q16 color matrix (BT.601 analog weights, U/V already scaled)
    localparam logic [15:0] Y_R = 16'd19595;
    localparam logic [15:0] Y_G = 16'd38470;
    localparam logic [15:0] Y_B = 16'd7471;
    localparam logic [15:0] U_R = 16'd11058;   // subtracted
    localparam logic [15:0] U_G = 16'd21710;   // subtracted
    localparam logic [15:0] U_B = 16'd32768;
    localparam logic [15:0] V_R = 16'd32768;
    localparam logic [15:0] V_G = 16'd27439;   // subtracted
    localparam logic [15:0] V_B = 16'd5329;    // subtracted
    localparam logic signed [SUM_W-1:0] HALF_255 = 27'sd8355840;  // 127.5 in Q16

    // One classified pixel, front to back
    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [SIZE_W-1:0] stride;
        logic [POS_W-1:0]  ccol;
        logic [POS_W-1:0]  crow;
        logic [SIZE_W-1:0] cstride;
        logic              cvalid;
        logic              frame_end;
    } t_pix;

    // Zero means one, anything above the maximum saturates
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] ext;
        ext = SIZE_W'(v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (ext > maxv) begin
            return maxv;
        end
        return ext;
    endfunction

    // Negative gives 0, else floor(acc / 2^16) limited to 255
    function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] acc);
        if (acc[SUM_W-1]) begin
            return '0;
        end else if (|acc[SUM_W-2:24]) begin
            return '1;
        end
        return acc[23:16];
    endfunction

endpackage

// ===== design/rgb_to_ycbcr_planar_packer.sv =====
// RGB to Y/Cb/Cr converter with planar address generation.
//
// Input channel (i_valid / o_ready): one RGB pixel per item, raster order.
// Output channel (o_valid / i_ready): one item per pixel with the luma sample
// and its address (column + row * stride, stride = width padded to 16), plus
// a chroma pair and its plane address when the chroma mode samples this pixel
// (4:2:0, 4:2:2 or 4:4:4, top-left sample of each cell). Chroma fields are zero
// otherwise. o_frame_end marks the last pixel of the picture.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, index 0 chroma mode,
// 1 width, 2 height. Write only while no items are in flight.
//
// Throughput: one item per clock while the receiver takes results. Each
// accepted item is written into the queue, then loads the product stage
// (color matrix and row * stride), then its sum/clamp loads into the output
// register. A four-entry queue sits between the classifier (counters,
// sampling decision) and the arithmetic pipe, so input keeps flowing while
// the receiver stalls; o_ready drops only when the queue fills.
// Reset (synchronous, active low) clears the counters and the pipe and loads
// 4:2:0, 640 x 480.
module rgb_to_ycbcr_planar_packer #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rycp_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [rycp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [rycp_pkg::PIX_W-1:0]  i_red,
    input  logic [rycp_pkg::PIX_W-1:0]  i_green,
    input  logic [rycp_pkg::PIX_W-1:0]  i_blue,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rycp_pkg::ADDR_W-1:0] o_luma_addr,
    output logic [rycp_pkg::PIX_W-1:0]  o_luma,
    output logic                        o_chroma_valid,
    output logic [rycp_pkg::ADDR_W-1:0] o_chroma_addr,
    output logic [rycp_pkg::PIX_W-1:0]  o_cb_sample,
    output logic [rycp_pkg::PIX_W-1:0]  o_cr_sample,
    output logic                        o_frame_end
);
    import rycp_pkg::*;

    t_pix push_item;   // classified pixel into the queue
    t_pix head_item;   // oldest queued pixel
    logic push, full, pop, head_valid;

    // front: config registers, raster counters, sampling decision
    rycp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_full      (full),
        .o_push      (push),
        .o_item      (push_item)
    );

    // decoupling queue
    rycp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_item)
    );

    // back: color matrix, clamps, address multiply, output register
    rycp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_luma_addr    (o_luma_addr),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_addr  (o_chroma_addr),
        .o_cb_sample    (o_cb_sample),
        .o_cr_sample    (o_cr_sample),
        .o_frame_end    (o_frame_end)
    );

endmodule

// ===== design/rycp_fifo.sv =====
module rycp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rycp_pkg::t_pix i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rycp_pkg::t_pix o_head
);
    import rycp_pkg::*;

    t_pix              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/rycp_front.sv =====
module rycp_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rycp_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [rycp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rycp_pkg::PIX_W-1:0]     i_red,
    input  logic [rycp_pkg::PIX_W-1:0]     i_green,
    input  logic [rycp_pkg::PIX_W-1:0]     i_blue,
    input  logic                           i_full,
    output logic                           o_push,
    output rycp_pkg::t_pix                 o_item
);
    import rycp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [MODE_W-1:0] r_chroma_mode;
    logic [CFG_W-1:0]  r_image_width;
    logic [CFG_W-1:0]  r_image_height;
    logic [CW-1:0]     r_column, n_column;
    logic [RW-1:0]     r_row, n_row;

    logic [SIZE_W-1:0] w, h, stride, half;
    logic [SIZE_W-1:0] col_ext, row_ext;
    logic              line_end, frame_end;

    assign w       = eff_size(r_image_width,  SIZE_W'(MAX_WIDTH));
    assign h       = eff_size(r_image_height, SIZE_W'(MAX_HEIGHT));
    assign stride  = (w + SIZE_W'(15)) & ~SIZE_W'(15);
    assign half    = stride >> 1;
    assign col_ext = SIZE_W'(r_column);
    assign row_ext = SIZE_W'(r_row);

    // >= so a counter left beyond a shrunken size still wraps
    assign line_end  = (col_ext + SIZE_W'(1)) >= w;
    assign frame_end = line_end && ((row_ext + SIZE_W'(1)) >= h);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item           = '0;
        o_item.red       = i_red;
        o_item.green     = i_green;
        o_item.blue      = i_blue;
        o_item.col       = POS_W'(r_column);
        o_item.row       = POS_W'(r_row);
        o_item.stride    = stride;
        o_item.frame_end = frame_end;
        unique case (r_chroma_mode)
            CM_420: begin
                o_item.cvalid  = !r_column[0] && !r_row[0];
                o_item.ccol    = POS_W'(r_column >> 1);
                o_item.crow    = POS_W'(r_row >> 1);
                o_item.cstride = half;
            end
            CM_444: begin
                o_item.cvalid  = 1'b1;
                o_item.ccol    = POS_W'(r_column);
                o_item.crow    = POS_W'(r_row);
                o_item.cstride = stride;
            end
            default: begin  // 4:2:2 and the unused code
                o_item.cvalid  = !r_column[0];
                o_item.ccol    = POS_W'(r_column >> 1);
                o_item.crow    = POS_W'(r_row);
                o_item.cstride = half;
            end
        endcase
    end

    always_comb begin
        n_column = r_column;
        n_row    = r_row;
        if (o_push) begin
            if (line_end) begin
                n_column = '0;
                n_row    = frame_end ? '0 : r_row + 1'b1;
            end else begin
                n_column = r_column + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_mode  <= CM_420;
            r_image_width  <= WIDTH_RESET;
            r_image_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CHROMA_MODE:  r_chroma_mode  <= i_cfg_data[MODE_W-1:0];
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== design/rycp_back.sv =====
module rycp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  rycp_pkg::t_pix              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rycp_pkg::ADDR_W-1:0] o_luma_addr,
    output logic [rycp_pkg::PIX_W-1:0]  o_luma,
    output logic                        o_chroma_valid,
    output logic [rycp_pkg::ADDR_W-1:0] o_chroma_addr,
    output logic [rycp_pkg::PIX_W-1:0]  o_cb_sample,
    output logic [rycp_pkg::PIX_W-1:0]  o_cr_sample,
    output logic                        o_frame_end
);
    import rycp_pkg::*;

    logic en;

    // stage 1: products
    logic              r_s1_valid;
    logic [PROD_W-1:0] r_yr, r_yg, r_yb, r_ur, r_ug, r_ub, r_vr, r_vg, r_vb;
    logic [ADDR_W-1:0] r_lprod, r_cprod;
    logic [POS_W-1:0]  r_col, r_ccol;
    logic              r_cvalid, r_frame_end;

    // stage 2: sums, clamp, output register
    logic              r_out_valid;
    logic signed [SUM_W-1:0] ysum, usum, vsum;

    // whole pipe moves when the output slot is free or being taken
    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_head_valid;

    function automatic logic [PROD_W-1:0] cmul(input logic [PIX_W-1:0] s,
                                               input logic [15:0] c);
        return PROD_W'(s) * PROD_W'(c);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_head_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yr        <= cmul(i_head.red,   Y_R);
            r_yg        <= cmul(i_head.green, Y_G);
            r_yb        <= cmul(i_head.blue,  Y_B);
            r_ur        <= cmul(i_head.red,   U_R);
            r_ug        <= cmul(i_head.green, U_G);
            r_ub        <= cmul(i_head.blue,  U_B);
            r_vr        <= cmul(i_head.red,   V_R);
            r_vg        <= cmul(i_head.green, V_G);
            r_vb        <= cmul(i_head.blue,  V_B);
            // addresses wrap modulo 2^24
            r_lprod     <= ADDR_W'(i_head.row)  * ADDR_W'(i_head.stride);
            r_cprod     <= ADDR_W'(i_head.crow) * ADDR_W'(i_head.cstride);
            r_col       <= i_head.col;
            r_ccol      <= i_head.ccol;
            r_cvalid    <= i_head.cvalid;
            r_frame_end <= i_head.frame_end;
        end
    end

    assign ysum = $signed(SUM_W'(r_yr)) + $signed(SUM_W'(r_yg)) + $signed(SUM_W'(r_yb));
    assign usum = HALF_255 - $signed(SUM_W'(r_ur)) - $signed(SUM_W'(r_ug))
                + $signed(SUM_W'(r_ub));
    assign vsum = HALF_255 + $signed(SUM_W'(r_vr)) - $signed(SUM_W'(r_vg))
                - $signed(SUM_W'(r_vb));

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_luma_addr    <= r_lprod + ADDR_W'(r_col);
            o_luma         <= clamp_q16(ysum);
            o_chroma_valid <= r_cvalid;
            o_chroma_addr  <= r_cvalid ? r_cprod + ADDR_W'(r_ccol) : '0;
            o_cb_sample    <= r_cvalid ? clamp_q16(usum) : '0;
            o_cr_sample    <= r_cvalid ? clamp_q16(vsum) : '0;
            o_frame_end    <= r_frame_end;
        end
    end

    assign o_valid = r_out_valid;

endmodule
